// ----- rtl/core/pps_pkg.sv -----
`timescale 1ns / 1ps

package pps_pkg;

    localparam int NUM_LEVELS_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int BURST_BITS_DEF  = 8;
    localparam int TIME_BITS_DEF   = 16;

    localparam int NUM_IDS  = 16;
    localparam int ID_W     = 4;
    localparam int PRIO_W   = 3;
    localparam int BURST_W  = 8;
    localparam int SLOT_W   = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // queue pointer operations for one cycle
    typedef struct packed {
        logic push;
        logic pop;
    } pps_qop_t;

    // process table operations for one cycle
    typedef struct packed {
        logic load;
        logic run;
    } pps_top_t;

endpackage

// ----- rtl/core/pps_ram.sv -----
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/pps_queue_ctrl.sv -----
`timescale 1ns / 1ps

module pps_queue_ctrl import pps_pkg::*; #(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
    localparam int PW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int AW = $clog2(NUM_LEVELS * QUEUE_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  pps_qop_t      op,
    input  logic [LW-1:0] push_lvl,
    input  logic [LW-1:0] pop_lvl,
    output logic [AW-1:0] push_addr,
    output logic [AW-1:0] pop_addr,
    output logic          push_full,
    output logic [LW-1:0] top_lvl,
    output logic          any_ready
);

    logic [PW-1:0] head_reg  [NUM_LEVELS];
    logic [PW-1:0] tail_reg  [NUM_LEVELS];
    logic [CW-1:0] count_reg [NUM_LEVELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (op.push && push_lvl == LW'(l)) begin
                    tail_reg[l]  <= (tail_reg[l] == PW'(QUEUE_DEPTH - 1)) ? '0
                                    : tail_reg[l] + 1'b1;
                    count_reg[l] <= count_reg[l] + 1'b1;
                end
                if (op.pop && pop_lvl == LW'(l)) begin
                    head_reg[l]  <= (head_reg[l] == PW'(QUEUE_DEPTH - 1)) ? '0
                                    : head_reg[l] + 1'b1;
                    count_reg[l] <= count_reg[l] - 1'b1;
                end
            end
        end
    end

    // lowest index wins: level 1 sits at index 0
    always_comb begin
        top_lvl   = '0;
        any_ready = 1'b0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (count_reg[l] != '0) begin
                top_lvl   = LW'(l);
                any_ready = 1'b1;
            end
        end
    end

    assign push_full = (count_reg[push_lvl] == CW'(QUEUE_DEPTH));
    assign push_addr = AW'(push_lvl) * AW'(QUEUE_DEPTH) + AW'(tail_reg[push_lvl]);
    assign pop_addr  = AW'(pop_lvl) * AW'(QUEUE_DEPTH) + AW'(head_reg[pop_lvl]);

endmodule

// ----- rtl/core/pps_proc_table.sv -----
`timescale 1ns / 1ps

module pps_proc_table import pps_pkg::*; #(
    parameter int BURST_BITS = BURST_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pps_top_t              op,
    input  logic [ID_W-1:0]       id,
    input  logic [BURST_BITS-1:0] load_burst,
    output logic                  run_first,
    output logic                  run_done
);

    logic [BURST_BITS-1:0] remaining_reg [NUM_IDS];
    logic [NUM_IDS-1:0]    started_reg;
    logic [BURST_BITS-1:0] rem;
    logic [BURST_BITS-1:0] rem_next;

    // shared decrementer, saturating at zero
    assign rem       = remaining_reg[id];
    assign rem_next  = (rem != '0) ? rem - 1'b1 : rem;
    assign run_done  = (rem_next == '0);
    assign run_first = !started_reg[id];

    always_ff @(posedge aclk) begin
        if (op.load) begin
            remaining_reg[id] <= load_burst;
        end else if (op.run) begin
            remaining_reg[id] <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= '0;
        end else if (op.load) begin
            started_reg[id] <= 1'b0;
        end else if (op.run) begin
            started_reg[id] <= 1'b1;
        end
    end

endmodule

// ----- rtl/core/preemptive_priority_scheduler_core.sv -----
`timescale 1ns / 1ps
// Arrive request: accepted in ST_IDLE, then written to the queue and process tables in ST_EXEC.
// Tick request: accepted in ST_IDLE, head read from the queue RAM in ST_EXEC, then run and requeue in ST_RUN;
// an idle tick answers from ST_EXEC. m_tready low holds a request in its last cycle.
// One request in flight; the result register frees the input side while it waits.
// Synchronous active-low reset empties all queues, clears started flags and the slot counter;
// no clearing pass, stored ids and burst counts are only read after being written.
module preemptive_priority_scheduler_core import pps_pkg::*; #(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BURST_BITS  = BURST_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // proc_id, priority_req, burst, zero pad
    input  logic                s_tuser,  // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // ran, run_id, first_run, finished,
                                          // slot_time, dropped, all_empty, zero pad
);

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int AW = $clog2(NUM_LEVELS * QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RUN
    } state_t;

    state_t                state_reg;
    logic                  cmd_reg;
    logic [ID_W-1:0]       id_reg;
    logic [PRIO_W-1:0]     prio_reg;
    logic [BURST_W-1:0]    burst_reg;
    logic [LW-1:0]         lvl_reg;
    logic [TIME_BITS-1:0]  time_reg;

    logic                  m_valid_reg;
    logic                  ran_reg;
    logic [ID_W-1:0]       run_id_reg;
    logic                  first_reg;
    logic                  fin_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  drop_reg;
    logic                  empty_reg;

    pps_qop_t              qop;
    pps_top_t              top;
    logic [LW-1:0]         push_lvl;
    logic [AW-1:0]         push_addr;
    logic [AW-1:0]         pop_addr;
    logic                  push_full;
    logic [LW-1:0]         top_lvl;
    logic                  any_ready;
    logic                  ram_we;
    logic                  ram_re;
    logic [ID_W-1:0]       ram_wdata;
    logic [ID_W-1:0]       ram_rdata;
    logic [ID_W-1:0]       tab_id;
    logic                  run_first;
    logic                  run_done;

    logic                  out_free;
    logic                  prio_ok;
    logic [LW-1:0]         arr_lvl;
    logic [BURST_BITS-1:0] arr_burst;
    logic                  arr_drop;
    logic                  do_arrive;
    logic                  do_idle;
    logic                  do_pop;
    logic                  do_run;
    logic [SLOT_W-1:0]     slot_now;

    assign out_free  = !m_valid_reg || m_tready;
    assign prio_ok   = (prio_reg != '0) && (32'(prio_reg) <= NUM_LEVELS);
    assign arr_lvl   = LW'(prio_reg - 1'b1);
    assign arr_burst = BURST_BITS'(40'(burst_reg));
    assign arr_drop  = (arr_burst == '0) || !prio_ok || push_full;
    assign slot_now  = SLOT_W'(80'(time_reg));

    assign do_arrive = (state_reg == ST_EXEC) && (cmd_reg == CMD_ARRIVE) && out_free;
    assign do_idle   = (state_reg == ST_EXEC) && (cmd_reg == CMD_TICK) && !any_ready
                       && out_free;
    assign do_pop    = (state_reg == ST_EXEC) && (cmd_reg == CMD_TICK) && any_ready;
    assign do_run    = (state_reg == ST_RUN) && out_free;

    assign push_lvl  = (state_reg == ST_RUN) ? lvl_reg : arr_lvl;
    assign qop.push  = (do_arrive && !arr_drop) || (do_run && !run_done);
    assign qop.pop   = do_pop;
    assign top.load  = do_arrive && !arr_drop;
    assign top.run   = do_run;
    assign tab_id    = (state_reg == ST_RUN) ? ram_rdata : id_reg;

    assign ram_we    = qop.push;
    assign ram_wdata = (state_reg == ST_RUN) ? ram_rdata : id_reg;
    assign ram_re    = do_pop;

    pps_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_LEVELS * QUEUE_DEPTH)
    ) u_ready_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (push_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pop_addr),
        .rdata (ram_rdata)
    );

    pps_queue_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (qop),
        .push_lvl  (push_lvl),
        .pop_lvl   (top_lvl),
        .push_addr (push_addr),
        .pop_addr  (pop_addr),
        .push_full (push_full),
        .top_lvl   (top_lvl),
        .any_ready (any_ready)
    );

    pps_proc_table #(
        .BURST_BITS (BURST_BITS)
    ) u_proc_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (top),
        .id         (tab_id),
        .load_burst (arr_burst),
        .run_first  (run_first),
        .run_done   (run_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            time_reg    <= '0;
        end else begin
            if (m_tready && !(do_arrive || do_idle || do_run)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tuser;
                        id_reg    <= s_tdata[3:0];
                        prio_reg  <= s_tdata[6:4];
                        burst_reg <= s_tdata[14:7];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (do_pop) begin
                        lvl_reg   <= top_lvl;
                        state_reg <= ST_RUN;
                    end else if (do_arrive) begin
                        m_valid_reg <= 1'b1;
                        ran_reg     <= 1'b0;
                        run_id_reg  <= '0;
                        first_reg   <= 1'b0;
                        fin_reg     <= 1'b0;
                        slot_reg    <= slot_now;
                        drop_reg    <= arr_drop;
                        empty_reg   <= arr_drop && !any_ready;
                        state_reg   <= ST_IDLE;
                    end else if (do_idle) begin
                        m_valid_reg <= 1'b1;
                        ran_reg     <= 1'b0;
                        run_id_reg  <= '0;
                        first_reg   <= 1'b0;
                        fin_reg     <= 1'b0;
                        slot_reg    <= slot_now;
                        drop_reg    <= 1'b0;
                        empty_reg   <= 1'b1;
                        time_reg    <= time_reg + 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_RUN: begin
                    if (do_run) begin
                        m_valid_reg <= 1'b1;
                        ran_reg     <= 1'b1;
                        run_id_reg  <= ram_rdata;
                        first_reg   <= run_first;
                        fin_reg     <= run_done;
                        slot_reg    <= slot_now;
                        drop_reg    <= 1'b0;
                        empty_reg   <= run_done && !any_ready;
                        time_reg    <= time_reg + 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, empty_reg, drop_reg, slot_reg, fin_reg, first_reg,
                       run_id_reg, ran_reg};

endmodule

// ----- dv/preemptive_priority_scheduler_core_test.sv -----
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_test;
    import pps_pkg::*;

    typedef struct packed {
        logic              ran;
        logic [ID_W-1:0]   run_id;
        logic              first_run;
        logic              finished;
        logic [SLOT_W-1:0] slot_time;
        logic              dropped;
        logic              all_empty;
    } sched_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // scheduler state as predicted
    logic [ID_W-1:0]    ready_ring [NUM_LEVELS_DEF][QUEUE_DEPTH_DEF];
    int                 ring_head  [NUM_LEVELS_DEF];
    int                 ring_tail  [NUM_LEVELS_DEF];
    int                 ring_count [NUM_LEVELS_DEF];
    logic [BURST_W-1:0] work_left  [NUM_IDS];
    logic               started    [NUM_IDS];
    logic [SLOT_W-1:0]  slot_count;

    sched_result_t outcome_q[$];
    sched_result_t want;
    int            failures = 0;
    bit            no_gaps = 1'b0;

    preemptive_priority_scheduler_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic void push_ready(int lvl, logic [ID_W-1:0] id);
        ready_ring[lvl][ring_tail[lvl]] = id;
        ring_tail[lvl] = (ring_tail[lvl] + 1) % QUEUE_DEPTH_DEF;
        ring_count[lvl]++;
    endfunction

    function automatic sched_result_t schedule_step(logic cmd, logic [ID_W-1:0] id,
            logic [PRIO_W-1:0] prio, logic [BURST_W-1:0] burst);
        sched_result_t r;
        logic [ID_W-1:0] pid;
        bit found;
        int total;
        r = '0;
        found = 1'b0;
        total = 0;
        r.slot_time = slot_count;
        if (cmd == CMD_ARRIVE) begin
            if (burst == 0 || prio < 1 || prio > NUM_LEVELS_DEF ||
                ring_count[prio-1] >= QUEUE_DEPTH_DEF) begin
                r.dropped = 1'b1;
            end else begin
                work_left[id] = burst;
                started[id] = 1'b0;
                push_ready(prio - 1, id);
            end
        end else begin
            for (int lvl = 0; lvl < NUM_LEVELS_DEF; lvl++) begin
                if (!found && ring_count[lvl] != 0) begin
                    found = 1'b1;
                    pid = ready_ring[lvl][ring_head[lvl]];
                    ring_head[lvl] = (ring_head[lvl] + 1) % QUEUE_DEPTH_DEF;
                    ring_count[lvl]--;
                    r.ran = 1'b1;
                    r.run_id = pid;
                    r.first_run = !started[pid];
                    started[pid] = 1'b1;
                    // a second queue entry of a re-arrived id may find no work left
                    if (work_left[pid] != 0)
                        work_left[pid]--;
                    if (work_left[pid] == 0)
                        r.finished = 1'b1;
                    else
                        push_ready(lvl, pid);
                end
            end
            slot_count++;
        end
        for (int lvl = 0; lvl < NUM_LEVELS_DEF; lvl++)
            total += ring_count[lvl];
        r.all_empty = (total == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [SLOT_W-1:0] exp_val,
            logic [SLOT_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                failures++;
            end else begin
                want = outcome_q.pop_front();
                check_field("ran", SLOT_W'(want.ran), SLOT_W'(m_tdata[0]));
                check_field("run_id", SLOT_W'(want.run_id), SLOT_W'(m_tdata[4:1]));
                check_field("first_run", SLOT_W'(want.first_run), SLOT_W'(m_tdata[5]));
                check_field("finished", SLOT_W'(want.finished), SLOT_W'(m_tdata[6]));
                check_field("slot_time", want.slot_time, m_tdata[22:7]);
                check_field("dropped", SLOT_W'(want.dropped), SLOT_W'(m_tdata[23]));
                check_field("all_empty", SLOT_W'(want.all_empty), SLOT_W'(m_tdata[24]));
                check_field("pad", '0, SLOT_W'(m_tdata[M_DATA_W-1:25]));
            end
        end
    end

    // result side stalls
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready));
        end
    end

    task automatic send_request(logic cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
            logic [BURST_W-1:0] burst);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W-ID_W-PRIO_W-BURST_W){1'b0}}, burst, prio, id};
        do @(posedge aclk); while (s_tready !== 1'b1);
        outcome_q.push_back(schedule_step(cmd, id, prio, burst));
    endtask

    task automatic tick();
        send_request(CMD_TICK, ID_W'($urandom), PRIO_W'($urandom), BURST_W'($urandom));
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_idle_tick();
        tick();
    endtask

    task automatic test_arrival_limits();
        send_request(CMD_ARRIVE, 4'd0, 3'd1, 8'd1);
        send_request(CMD_ARRIVE, 4'd15, 3'd4, 8'd255);
        send_request(CMD_ARRIVE, 4'd7, 3'd0, 8'd9);    // level zero
        send_request(CMD_ARRIVE, 4'd7, 3'd5, 8'd9);    // level above range
        send_request(CMD_ARRIVE, 4'd7, 3'd7, 8'd9);
        send_request(CMD_ARRIVE, 4'd9, 3'd2, 8'd0);    // zero burst
        send_request(CMD_ARRIVE, 4'd10, 3'd3, 8'd128);
    endtask

    task automatic test_preemption();
        tick();
        tick();
        send_request(CMD_ARRIVE, 4'd6, 3'd1, 8'd2);
        tick();
        tick();
        tick();
    endtask

    task automatic test_repeated_id();
        send_request(CMD_ARRIVE, 4'd3, 3'd2, 8'd1);
        send_request(CMD_ARRIVE, 4'd3, 3'd2, 8'd1);
        tick();
        tick();
    endtask

    task automatic test_full_level();
        repeat (QUEUE_DEPTH_DEF + 1)
            send_request(CMD_ARRIVE, ID_W'($urandom), 3'd2, 8'd1);
        wait_for_results();
    endtask

    task automatic test_random_traffic(int n_items);
        int sent, span, arrive_pct, roll;
        logic [PRIO_W-1:0] prio;
        logic [BURST_W-1:0] burst;
        sent = 0;
        while (sent < n_items) begin
            span = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: arrive_pct = 20;
                1: arrive_pct = 40;
                default: arrive_pct = 70;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (span) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    if ($urandom_range(0, 1) == 0) begin
                        prio = PRIO_W'($urandom_range(1, NUM_LEVELS_DEF));
                        burst = '0;
                    end else begin
                        case ($urandom_range(0, 3))
                            0: prio = 3'd0;
                            1: prio = 3'd5;
                            2: prio = 3'd6;
                            default: prio = 3'd7;
                        endcase
                        burst = BURST_W'($urandom);
                    end
                    send_request(CMD_ARRIVE, ID_W'($urandom), prio, burst);
                end else if (roll < 8 + arrive_pct) begin
                    prio = PRIO_W'($urandom_range(1, NUM_LEVELS_DEF));
                    if ($urandom_range(0, 11) == 0)
                        burst = BURST_W'($urandom_range(1, 255));
                    else
                        burst = BURST_W'($urandom_range(1, 4));
                    send_request(CMD_ARRIVE, ID_W'($urandom), prio, burst);
                end else begin
                    tick();
                end
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_for_results();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = CMD_ARRIVE;
        s_tdata  = '0;
        for (int lvl = 0; lvl < NUM_LEVELS_DEF; lvl++) begin
            ring_head[lvl]  = 0;
            ring_tail[lvl]  = 0;
            ring_count[lvl] = 0;
        end
        for (int i = 0; i < NUM_IDS; i++) begin
            work_left[i] = '0;
            started[i]   = 1'b0;
        end
        slot_count = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_tick();
        test_arrival_limits();
        test_preemption();
        test_repeated_id();
        test_full_level();
        test_random_traffic(950);
        test_drain_pause();
        test_random_traffic(900);
        test_random_traffic(50);

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (failures == 0 && outcome_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_queue_ctrl.sv
rtl/core/pps_proc_table.sv
rtl/core/preemptive_priority_scheduler_core.sv
dv/preemptive_priority_scheduler_core_test.sv
